// ===== rtl/lltag_pkg.sv =====
package lltag_pkg;

	// field widths
	localparam int CMD_W  = 3;
	localparam int ID_W   = 64;
	localparam int TAG_W  = 10;
	localparam int CFG_W  = 11;
	localparam int CNT_W  = 32;
	localparam int STAT_W = 2;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_TAG_COUNT = 1'b0;
	localparam logic [CFG_W-1:0] TAG_COUNT_RST = 11'd1;

	// default depth of the per-tag count memory
	localparam int MAX_TAGS_DEF = 1024;

	// command codes
	localparam logic [CMD_W-1:0] CMD_OBSERVE_ID  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_OBSERVE_TAG = 3'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ALLOCATE    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_COUNT = 2'd2;

endpackage

// ===== rtl/least_loaded_tag_allocator.sv =====
// Least-loaded tag allocator.
// Input channel (in_valid / in_stall) carries one command per transaction:
// observe a stream id, observe a tag, query a tag, allocate, or clear.
// Output channel (out_valid / out_stall) returns exactly one result per
// command: status, new_stream_id, chosen_tag and has_streams.
// The per-tag stream counts live in a MAX_TAGS x 32 synchronous memory with
// one read and one write port; commands are handled one at a time.
// Steps per command, from acceptance to result valid:
//   observe id, unknown codes : no memory access
//   observe tag, query        : memory read; observe tag then increments and writes back
//   allocate                  : scan of the first tag_count counts (one count read per cycle)
//   allocate with an error    : no memory access
//   clear                     : all MAX_TAGS entries zeroed (one memory entry zeroed per cycle)
// The scan over the memory read port sets the allocate time.
// After reset the block runs a clearing pass over all MAX_TAGS entries with
// in_stall high; APB writes of tag_count are taken at any time.
// A result waits in the output register while out_stall is high; the next
// command is still accepted and processed, and it completes once the output
// register frees up.
module least_loaded_tag_allocator #(
	parameter int MAX_TAGS = lltag_pkg::MAX_TAGS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lltag_pkg::CMD_W-1:0]     cmd,
	input  logic [lltag_pkg::ID_W-1:0]      stream_id,
	input  logic [lltag_pkg::TAG_W-1:0]     tag_id,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lltag_pkg::STAT_W-1:0]    status,
	output logic [lltag_pkg::ID_W-1:0]      new_stream_id,
	output logic [lltag_pkg::TAG_W-1:0]     chosen_tag,
	output logic                            has_streams,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lltag_pkg::ADDR_W-1:0]    paddr,
	input  logic [lltag_pkg::DATA_W-1:0]    pwdata,
	output logic [lltag_pkg::DATA_W-1:0]    prdata,
	output logic                            pready
);

	localparam int TAG_AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
	localparam int CMPW   = (TAG_AW > lltag_pkg::CFG_W) ? TAG_AW : lltag_pkg::CFG_W;
	localparam logic [TAG_AW-1:0] LAST_ENTRY = TAG_AW'(MAX_TAGS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TAG,
		S_SCAN,
		S_CLR,
		S_EMIT
	} state_t;

	state_t state_q;

	// configuration and scalar state
	logic [lltag_pkg::CFG_W-1:0] tag_count_q;
	logic                        seen_q;
	logic [lltag_pkg::ID_W-1:0]  largest_q;

	// command being worked on
	logic [lltag_pkg::CMD_W-1:0] cmd_q;
	logic [TAG_AW-1:0]           tag_q;
	logic                        tag_ok_q;
	logic                        clr_reply_q;

	// scan and clear pointer
	logic [TAG_AW-1:0]           ptr_q;
	logic                        issue_done_q;
	logic                        rd_val_s1;
	logic                        rd_last_s1;
	logic [TAG_AW-1:0]           rd_idx_s1;
	logic [lltag_pkg::CNT_W-1:0] least_q;
	logic [TAG_AW-1:0]           pick_q;

	// pending result
	logic [lltag_pkg::STAT_W-1:0] res_status_q;
	logic [lltag_pkg::ID_W-1:0]   res_id_q;
	logic [lltag_pkg::TAG_W-1:0]  res_tag_q;
	logic                         res_has_q;

	// count memory
	logic [lltag_pkg::CNT_W-1:0] cnt_mem [MAX_TAGS];
	logic [lltag_pkg::CNT_W-1:0] mem_rdata_q;
	logic [TAG_AW-1:0]           mem_raddr;
	logic [TAG_AW-1:0]           mem_waddr;
	logic [lltag_pkg::CNT_W-1:0] mem_wdata;
	logic                        mem_we;

	logic accept;
	logic cfg_we;
	logic in_tag_ok;
	logic ids_exhausted;
	logic bad_count;
	logic alloc_cmd;
	logic alloc_go;
	logic [lltag_pkg::STAT_W-1:0] accept_status;
	logic scan_last;
	logic out_free;
	logic [CMPW-1:0] tc_m1;
	logic [TAG_AW-1:0] final_pick;
	logic [lltag_pkg::ID_W-1:0] next_id;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;

	// apb access
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == lltag_pkg::REG_TAG_COUNT);
	assign prdata = (paddr[2] == lltag_pkg::REG_TAG_COUNT) ?
		{{(lltag_pkg::DATA_W - lltag_pkg::CFG_W){1'b0}}, tag_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_count_q <= lltag_pkg::TAG_COUNT_RST;
		end else if (cfg_we) begin
			tag_count_q <= pwdata[lltag_pkg::CFG_W-1:0];
		end
	end

	// allocate checks and helpers
	assign in_tag_ok     = (32'(tag_id) < MAX_TAGS);
	assign ids_exhausted = seen_q && (&largest_q);
	assign bad_count     = (tag_count_q == '0) || (32'(tag_count_q) > MAX_TAGS);
	assign alloc_cmd     = (cmd == lltag_pkg::CMD_ALLOCATE);
	assign alloc_go      = alloc_cmd && !ids_exhausted && !bad_count;
	assign accept_status = !alloc_cmd    ? lltag_pkg::ST_OK :
	                       ids_exhausted ? lltag_pkg::ST_EXHAUSTED :
	                       bad_count     ? lltag_pkg::ST_BAD_COUNT : lltag_pkg::ST_OK;
	assign next_id       = seen_q ? (largest_q + 64'd1) : 64'd1;
	assign tc_m1         = CMPW'(tag_count_q) - CMPW'(1);
	assign scan_last     = (CMPW'(ptr_q) == tc_m1);
	assign final_pick    = (mem_rdata_q < least_q) ? rd_idx_s1 : pick_q;

	// memory port selection
	always_comb begin
		mem_raddr = ptr_q;
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = '0;
		case (state_q)
			S_IDLE: begin
				mem_raddr = TAG_AW'(tag_id);
			end
			S_TAG: begin
				mem_waddr = tag_q;
				mem_wdata = mem_rdata_q + 32'd1;
				mem_we    = (cmd_q == lltag_pkg::CMD_OBSERVE_TAG) && tag_ok_q && !(&mem_rdata_q);
			end
			S_CLR: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_raddr = ptr_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cnt_mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= cnt_mem[mem_raddr];
	end

	// command sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			seen_q       <= 1'b0;
			largest_q    <= '0;
			ptr_q        <= '0;
			clr_reply_q  <= 1'b0;
			issue_done_q <= 1'b0;
			rd_val_s1    <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if ((state_q == S_EMIT) && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q        <= cmd;
						tag_q        <= TAG_AW'(tag_id);
						tag_ok_q     <= in_tag_ok;
						res_status_q <= accept_status;
						res_id_q     <= alloc_go ? next_id : '0;
						res_tag_q    <= '0;
						res_has_q    <= 1'b0;
						case (cmd)
							lltag_pkg::CMD_OBSERVE_ID: begin
								seen_q <= 1'b1;
								if (stream_id > largest_q) begin
									largest_q <= stream_id;
								end
								state_q <= S_EMIT;
							end
							lltag_pkg::CMD_OBSERVE_TAG, lltag_pkg::CMD_QUERY: begin
								state_q <= S_TAG;
							end
							lltag_pkg::CMD_ALLOCATE: begin
								if (alloc_go) begin
									ptr_q        <= '0;
									issue_done_q <= 1'b0;
									rd_val_s1    <= 1'b0;
									least_q      <= '1;
									pick_q       <= '0;
									state_q      <= S_SCAN;
								end else begin
									state_q <= S_EMIT;
								end
							end
							lltag_pkg::CMD_CLEAR: begin
								seen_q      <= 1'b0;
								largest_q   <= '0;
								ptr_q       <= '0;
								clr_reply_q <= 1'b1;
								state_q     <= S_CLR;
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_TAG: begin
					// count read is back; write-back happens in the memory block
					res_has_q <= (cmd_q == lltag_pkg::CMD_QUERY) && tag_ok_q &&
						(mem_rdata_q != '0);
					state_q   <= S_EMIT;
				end
				S_SCAN: begin
					// issue one count read per cycle
					if (!issue_done_q) begin
						rd_val_s1  <= 1'b1;
						rd_idx_s1  <= ptr_q;
						rd_last_s1 <= scan_last;
						ptr_q      <= ptr_q + TAG_AW'(1);
						if (scan_last) begin
							issue_done_q <= 1'b1;
						end
					end else begin
						rd_val_s1 <= 1'b0;
					end
					// keep the first strictly smaller count
					if (rd_val_s1) begin
						if (mem_rdata_q < least_q) begin
							least_q <= mem_rdata_q;
							pick_q  <= rd_idx_s1;
						end
						if (rd_last_s1) begin
							res_tag_q <= lltag_pkg::TAG_W'(final_pick);
							state_q   <= S_EMIT;
						end
					end
				end
				S_CLR: begin
					// zero one entry per cycle
					if (ptr_q == LAST_ENTRY) begin
						ptr_q       <= '0;
						clr_reply_q <= 1'b0;
						state_q     <= clr_reply_q ? S_EMIT : S_IDLE;
					end else begin
						ptr_q <= ptr_q + TAG_AW'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						status        <= res_status_q;
						new_stream_id <= res_id_q;
						chosen_tag    <= res_tag_q;
						has_streams   <= res_has_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// an error result carries no identifier or tag
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != lltag_pkg::ST_OK) |-> (new_stream_id == '0) && (chosen_tag == '0))
		else $error("error result with nonzero payload");

	// has_streams only comes with a plain ok result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_streams |-> (status == lltag_pkg::ST_OK) && (new_stream_id == '0))
		else $error("has_streams set on a non-query result");

	// the scan never reads beyond the tags in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && !issue_done_q |-> (CMPW'(ptr_q) <= tc_m1))
		else $error("scan pointer beyond tag_count");

	// the count memory is never written during a scan
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !mem_we)
		else $error("count memory written during scan");

	// a new result is only loaded when the output register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_stream_id) && $stable(status))
		else $error("pending result overwritten");

endmodule

// ===== tb/sv/lltag_sb_pkg.sv =====
`timescale 1ns / 1ps

package lltag_sb_pkg;

	import lltag_pkg::*;

	// command codes that the block answers with an all-zero result
	localparam logic [CMD_W-1:0] CMD_SPARE0 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE1 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE2 = 3'd7;

	// one result transaction
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   new_id;
		logic [TAG_W-1:0]  tag;
		logic              has;
	} alloc_result_t;

	class lltag_scoreboard;

		logic [CFG_W-1:0] tag_count;
		bit               seen_any;
		logic [ID_W-1:0]  largest_id;
		logic [CNT_W-1:0] tag_load [MAX_TAGS_DEF];
		alloc_result_t    expected_q [$];
		int               mismatches;

		function new();
			tag_count  = TAG_COUNT_RST;
			mismatches = 0;
			clear_loads();
		endfunction

		// stream tracking and per-tag loads back to their reset values
		function void clear_loads();
			seen_any   = 1'b0;
			largest_id = '0;
			foreach (tag_load[i])
				tag_load[i] = '0;
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		// update the tracked state for an accepted command and queue its result
		function void note_command(logic [CMD_W-1:0] c, logic [ID_W-1:0] sid,
			logic [TAG_W-1:0] tag);
			alloc_result_t    r;
			logic [CNT_W-1:0] least;
			int               pick;
			r = '0;
			case (c)
				CMD_OBSERVE_ID: begin
					seen_any = 1'b1;
					if (sid > largest_id)
						largest_id = sid;
				end
				CMD_OBSERVE_TAG: begin
					if (tag_load[tag] != '1)
						tag_load[tag]++;
				end
				CMD_QUERY: begin
					r.has = (tag_load[tag] != '0);
				end
				CMD_ALLOCATE: begin
					if (seen_any && largest_id == '1) begin
						r.status = ST_EXHAUSTED;
					end else if (tag_count == '0 || tag_count > MAX_TAGS_DEF) begin
						r.status = ST_BAD_COUNT;
					end else begin
						// lowest-numbered tag with the smallest load wins
						least = '1;
						pick  = 0;
						for (int t = 0; t < int'(tag_count); t++) begin
							if (tag_load[t] < least) begin
								least = tag_load[t];
								pick  = t;
							end
						end
						r.status = ST_OK;
						r.new_id = seen_any ? largest_id + 1'b1 : ID_W'(1);
						r.tag    = pick[TAG_W-1:0];
					end
				end
				CMD_CLEAR: begin
					clear_loads();
				end
				default: begin
				end
			endcase
			expected_q = {expected_q, r};
		endfunction

		// compare a result transaction with the oldest pending expectation
		function void check_result(alloc_result_t got);
			alloc_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result: status %0d id %h tag %0d has %0d",
					got.status, got.new_id, got.tag, got.has));
				return;
			end
			want = expected_q.pop_front();
			if (got.status != want.status || got.new_id != want.new_id ||
				got.tag != want.tag || got.has != want.has)
				report($sformatf({"result mismatch (expected/actual): status %0d/%0d ",
					"id %h/%h tag %0d/%0d has %0d/%0d"},
					want.status, got.status, want.new_id, got.new_id,
					want.tag, got.tag, want.has, got.has));
		endfunction

	endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

	import lltag_pkg::*;
	import lltag_sb_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 200;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 72;
	localparam logic [ADDR_W-1:0] TAG_COUNT_ADDR = {REG_TAG_COUNT, 2'b00};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [CMD_W-1:0]   cmd = '0;
	logic [ID_W-1:0]    stream_id = '0;
	logic [TAG_W-1:0]   tag_id = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [STAT_W-1:0]  status;
	logic [ID_W-1:0]    new_stream_id;
	logic [TAG_W-1:0]   chosen_tag;
	logic               has_streams;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	lltag_scoreboard tracker = new();
	int              cmds_accepted = 0;
	int              cycle_count = 0;
	bit              steady = 1'b0;
	bit              held_off = 1'b0;

	least_loaded_tag_allocator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.stream_id     (stream_id),
		.tag_id        (tag_id),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.new_stream_id (new_stream_id),
		.chosen_tag    (chosen_tag),
		.has_streams   (has_streams),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		alloc_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status = status;
			got.new_id = new_stream_id;
			got.tag    = chosen_tag;
			got.has    = has_streams;
			tracker.check_result(got);
		end
	end

	// result side: random stalls, one long hold-off to back the block up
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && cmds_accepted >= HOLD_AFTER) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				out_stall <= !steady && ($urandom_range(0, 99) < 29);
			end
		end
	end

	// offer one command transaction and wait for it to be taken
	task automatic send(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] sid,
		input logic [TAG_W-1:0] tag);
		if (!steady) begin
			while ($urandom_range(0, 99) < 29) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		stream_id <= sid;
		tag_id    <= tag;
		do @(posedge clk); while (in_stall);
		tracker.note_command(c, sid, tag);
		cmds_accepted++;
	endtask

	// quiet the command side, let every result come back, then write and read back
	task automatic set_tag_count(input logic [CFG_W-1:0] value);
		logic [DATA_W-1:0] readback;
		in_valid <= 1'b0;
		while (tracker.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TAG_COUNT_ADDR;
		pwdata  <= {(DATA_W - CFG_W)'($urandom_range(0, (1 << (DATA_W - CFG_W)) - 1)), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.tag_count = value;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback[CFG_W-1:0] != value)
			tracker.report($sformatf("tag_count readback (expected/actual): %0d/%0d",
				value, readback[CFG_W-1:0]));
	endtask

	// mostly well-formed traffic aimed at the tags in use, plus some noise
	task automatic send_random_cmd();
		int               roll;
		int               span;
		logic [ID_W-1:0]  sid;
		logic [TAG_W-1:0] tag;
		roll = $urandom_range(0, 99);
		span = (tracker.tag_count >= 1 && tracker.tag_count <= MAX_TAGS_DEF) ?
			int'(tracker.tag_count) : 16;
		sid  = {$urandom, $urandom};
		tag  = TAG_W'($urandom);
		if ($urandom_range(0, 3) != 0)
			tag = TAG_W'($urandom_range(0, span - 1));
		if (roll < 28) begin
			send(CMD_OBSERVE_TAG, sid, tag);
		end else if (roll < 43) begin
			send(CMD_QUERY, sid, tag);
		end else if (roll < 63) begin
			send(CMD_ALLOCATE, sid, tag);
		end else if (roll < 93) begin
			// identifiers: small, anywhere, close to the top, or the very top
			roll = $urandom_range(0, 99);
			if (roll < 50)
				sid = ID_W'($urandom_range(0, 5000));
			else if (roll < 85)
				sid = {$urandom, $urandom};
			else if (roll < 97)
				sid = '1 - ID_W'($urandom_range(1, 4));
			else
				sid = '1;
			send(CMD_OBSERVE_ID, sid, tag);
		end else if (roll < 96) begin
			send(CMD_CLEAR, sid, tag);
		end else begin
			send(CMD_SPARE0 + CMD_W'($urandom_range(0, 2)), sid, tag);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] tc;
		int               roll;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty state, tag loads, identifier tracking, spare codes
		send(CMD_ALLOCATE, '0, '0);
		send(CMD_QUERY, '1, 10'd0);
		send(CMD_OBSERVE_TAG, '0, 10'd0);
		send(CMD_OBSERVE_TAG, '1, 10'd0);
		send(CMD_OBSERVE_TAG, '0, '1);
		send(CMD_QUERY, '0, '1);
		send(CMD_QUERY, '1, 10'd0);
		send(CMD_QUERY, '0, 10'd1);
		send(CMD_ALLOCATE, '1, '1);
		send(CMD_OBSERVE_ID, '0, '1);
		send(CMD_ALLOCATE, '0, '0);
		send(CMD_OBSERVE_ID, 64'd5, '0);
		send(CMD_OBSERVE_ID, 64'd3, '0);
		send(CMD_ALLOCATE, '0, '0);
		send(CMD_SPARE0, {$urandom, $urandom}, TAG_W'($urandom));
		send(CMD_SPARE1, '1, '1);
		send(CMD_SPARE2, {$urandom, $urandom}, TAG_W'($urandom));

		// directed: tag count extremes, invalid counts, exhausted identifiers
		set_tag_count(11'd4);
		send(CMD_ALLOCATE, '0, '0);
		set_tag_count(11'd0);
		send(CMD_ALLOCATE, '0, '0);
		set_tag_count(11'd1025);
		send(CMD_ALLOCATE, '0, '0);
		set_tag_count(11'd2047);
		send(CMD_ALLOCATE, '0, '0);
		set_tag_count(11'd1024);
		send(CMD_ALLOCATE, '0, '0);
		send(CMD_OBSERVE_ID, '1, '0);
		send(CMD_ALLOCATE, '0, '0);
		set_tag_count(11'd0);
		send(CMD_ALLOCATE, '0, '0);
		set_tag_count(11'd1024);
		send(CMD_CLEAR, '1, '1);
		send(CMD_ALLOCATE, '0, '0);
		send(CMD_QUERY, '0, 10'd0);

		// random phases, each under its own tag count
		for (int p = 0; p < PHASES; p++) begin
			roll = $urandom_range(0, 99);
			if (p == 3 || roll < 8)
				tc = 11'd1024;
			else if (p == 5 || roll < 16)
				tc = ($urandom_range(0, 1) == 0) ? 11'd0 : CFG_W'($urandom_range(1025, 2047));
			else if (roll < 28)
				tc = CFG_W'($urandom_range(13, 64));
			else
				tc = CFG_W'($urandom_range(1, 12));
			set_tag_count(tc);
			steady = (p == 1);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random_cmd();
			steady = 1'b0;
		end

		// drain
		in_valid <= 1'b0;
		while (tracker.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lltag_pkg.sv
rtl/least_loaded_tag_allocator.sv
tb/sv/lltag_sb_pkg.sv
tb/sv/tb.sv
